// File: sv/tiled_ycbcr_to_rgb_pixel_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tiled YCbCr-to-RGB pixel block
// Property wrappers that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TILED_YCBCR_TO_RGB_PIXEL_TOP_ASSERT_SVH
`define TILED_YCBCR_TO_RGB_PIXEL_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define TYC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tiled ycbcr assertion failed");

// Next-cycle implication, checked out of reset.
`define TYC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tiled ycbcr assertion failed");

`else

`define TYC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define TYC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: sv/tyc2rgb_pkg.sv
// ----------------------------------------------------------------------------
// tyc2rgb_pkg
// Shared constants, types and helpers of the tiled YCbCr-to-RGB pixel block.
// ----------------------------------------------------------------------------
package tyc2rgb_pkg;

    localparam int TILE_SIZE  = 32;
    localparam int TILE_LOG2  = 5;
    localparam int MAX_WIDTH  = 4096;

    localparam int COORD_W    = 12;
    localparam int BYTE_W     = 8;
    localparam int OFF_W      = 24;
    localparam int IMG_W_W    = 13;
    localparam int VFAC_W     = 2;
    localparam int TILES_W    = 8;
    localparam int TROW_W     = COORD_W - TILE_LOG2;
    localparam int OFF_HI_W   = OFF_W - 2 * TILE_LOG2;
    localparam int ROWMUL_W   = TROW_W + TILES_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = IMG_W_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_VERT = 2'd1;

    localparam logic [VFAC_W-1:0] VFAC_HALF  = 2'd2;
    localparam logic [VFAC_W-1:0] VFAC_THIRD = 2'd3;

    // Division by three of a 12-bit row: (y * 2731) >> 13 is exact for y < 4096.
    localparam int DIV3_RECIP = 2731;
    localparam int DIV3_SHIFT = 13;
    localparam int DIV3_PROD_W = COORD_W + DIV3_SHIFT;

    // Q16 color coefficients.
    localparam int Q_SHIFT = 16;
    localparam int K_CR_R  = 91881;
    localparam int K_CB_G  = 22554;
    localparam int K_CR_G  = 46802;
    localparam int K_CB_B  = 116130;
    localparam int PROD_W  = 26;
    localparam int ACC_W   = 27;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // Tiles per row from the raw width register, with width clamped to 1..MAX_WIDTH.
    function automatic logic [TILES_W-1:0] tiles_of(input logic [IMG_W_W-1:0] w);
        logic [IMG_W_W-1:0] wc;
        logic [IMG_W_W:0]   s;
        begin
            wc = w;
            if (w == '0)
            begin
                wc = IMG_W_W'(1);
            end
            else if (w > IMG_W_W'(MAX_WIDTH))
            begin
                wc = IMG_W_W'(MAX_WIDTH);
            end
            s = {1'b0, wc} + (IMG_W_W + 1)'(TILE_SIZE - 1);
            return s[TILE_LOG2 +: TILES_W];
        end
    endfunction

endpackage

// File: sv/tiled_ycbcr_to_rgb_pixel_top.sv
// ----------------------------------------------------------------------------
// tiled_ycbcr_to_rgb_pixel_top
// Per-pixel tiled plane offsets and JFIF YCbCr-to-RGB conversion.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  -------   -------------------   ------------------------------------------
//  input     s_tvalid / s_tready   s_tdata: pix_x, pix_y, luma, cb, cr
//  output    m_tvalid / m_tready   m_tdata: luma/cb/cr offsets, red, green, blue
//  config    cfg_valid/cfg_ready   cfg_index, cfg_data
//
// In the pipeline, stage one holds the luma row multiply, the divide-by-factor
// and the color products, stage two the luma sum, chroma row multiply and
// color accumulators, stage three the chroma sum and clamps and drives the
// output. One item can enter each cycle unless the pipeline is stalled. Each
// stage carries a valid bit and loads whenever it is empty or the stage after
// it moves, so a stall on the output fills the bubbles first and then holds
// every item in place. Reset clears the valid bits and sets the width and
// vertical factor to one; configuration writes are taken in any cycle.
//
module tiled_ycbcr_to_rgb_pixel_top
    import tyc2rgb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: pix_x[11:0], pix_y[23:12], luma_byte[31:24],
    // cb_byte[39:32], cr_byte[47:40].
    input  logic [47:0]           s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0: luma_offset[23:0], cb_offset[47:24], cr_offset[71:48],
    // red[79:72], green[87:80], blue[95:88].
    output logic [95:0]           m_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "tiled_ycbcr_to_rgb_pixel_top_assert.svh"

    // The configuration is kept as tiles per row, computed once at write time.
    logic [TILES_W-1:0] tiles_reg;
    logic [TILES_W-1:0] tiles_next;
    logic [VFAC_W-1:0]  vfac_reg;
    logic [VFAC_W-1:0]  vfac_next;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v1_next;
    logic v2_next;
    logic v3_next;

    stage_en_t en;

    logic [OFF_W-1:0]  luma_offset;
    logic [OFF_W-1:0]  cb_offset;
    logic [OFF_W-1:0]  cr_offset;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        tiles_next = tiles_reg;
        vfac_next  = vfac_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH: tiles_next = tiles_of(cfg_data);
                REG_CHROMA_VERT: vfac_next  = cfg_data[VFAC_W-1:0];
                default:         tiles_next = tiles_reg;
            endcase
        end
    end

    // A stage loads when it is empty or its contents move on this cycle.
    assign en.s3 = !v3_reg || m_tready;
    assign en.s2 = !v2_reg || en.s3;
    assign en.s1 = !v1_reg || en.s2;

    assign v1_next = en.s1 ? s_tvalid : v1_reg;
    assign v2_next = en.s2 ? v1_reg   : v2_reg;
    assign v3_next = en.s3 ? v2_reg   : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiles_reg <= TILES_W'(1);
            vfac_reg  <= VFAC_W'(1);
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            tiles_reg <= tiles_next;
            vfac_reg  <= vfac_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            v3_reg    <= v3_next;
        end
    end

    assign s_tready = en.s1;
    assign m_tvalid = v3_reg;

    // Factor zero behaves as one through the default arm of the row select.
    tyc2rgb_addr u_addr
    (
        .clk         (clk),
        .en          (en),
        .tiles       (tiles_reg),
        .vfactor     (vfac_reg),
        .pix_x       (s_tdata[11:0]),
        .pix_y       (s_tdata[23:12]),
        .luma_offset (luma_offset),
        .cb_offset   (cb_offset),
        .cr_offset   (cr_offset)
    );

    tyc2rgb_color u_color
    (
        .clk       (clk),
        .en        (en),
        .luma_byte (s_tdata[31:24]),
        .cb_byte   (s_tdata[39:32]),
        .cr_byte   (s_tdata[47:40]),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_tdata = {blue, green, red, cr_offset, cb_offset, luma_offset};

    // An empty last stage means nothing can hold the input back.
    `TYC_ASSERT_SAME(a_ready_when_drained, clk, rst_n, !v3_reg, s_tready)

    // An accepted item always occupies the first stage next cycle.
    `TYC_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, s_tvalid && s_tready, v1_reg)

    // The Cr offset is the Cb offset plus one on every delivered item.
    `TYC_ASSERT_SAME(a_cr_follows_cb, clk, rst_n, m_tvalid, (m_tdata[48] == 1'b1) && (m_tdata[24] == 1'b0) && (m_tdata[71:49] == m_tdata[47:25]))

    // The tiles-per-row register never leaves 1..128.
    `TYC_ASSERT_SAME(a_tiles_range, clk, rst_n, 1'b1, (tiles_reg != '0) && (tiles_reg <= TILES_W'(MAX_WIDTH / TILE_SIZE)))

endmodule

// File: sv/tyc2rgb_addr.sv
// ----------------------------------------------------------------------------
// tyc2rgb_addr
// Three-stage computation of the tiled luma and chroma byte offsets.
// ----------------------------------------------------------------------------
module tyc2rgb_addr
    import tyc2rgb_pkg::*;
(
    input  logic                 clk,
    input  stage_en_t            en,
    input  logic [TILES_W-1:0]   tiles,
    input  logic [VFAC_W-1:0]    vfactor,
    input  logic [COORD_W-1:0]   pix_x,
    input  logic [COORD_W-1:0]   pix_y,
    output logic [OFF_W-1:0]     luma_offset,
    output logic [OFF_W-1:0]     cb_offset,
    output logic [OFF_W-1:0]     cr_offset
);

    logic [DIV3_PROD_W-1:0] div3_prod;
    logic [COORD_W-1:0]     cy_next;

    // Stage 1
    logic [COORD_W-1:0]   x1_reg;
    logic [TILE_LOG2-1:0] yl1_reg;
    logic [COORD_W-1:0]   cy1_reg;
    logic [ROWMUL_W-1:0]  lmul1_reg;

    // Stage 2
    logic [COORD_W-1:0]   x2_reg;
    logic [TILE_LOG2-1:0] cyl2_reg;
    logic [ROWMUL_W-1:0]  cmul2_reg;
    logic [OFF_W-1:0]     loff2_reg;
    logic [OFF_HI_W-1:0]  lhi_next;

    // Stage 3
    logic [OFF_HI_W-1:0]  chi_next;
    logic [OFF_W-1:0]     loff3_reg;
    logic [OFF_W-1:0]     coff3_reg;

    assign div3_prod = DIV3_PROD_W'(pix_y) * DIV3_PROD_W'(DIV3_RECIP);

    always_comb
    begin
        case (vfactor)
            VFAC_HALF:  cy_next = {1'b0, pix_y[COORD_W-1:1]};
            VFAC_THIRD: cy_next = div3_prod[DIV3_SHIFT +: COORD_W];
            default:    cy_next = pix_y;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            x1_reg    <= pix_x;
            yl1_reg   <= pix_y[TILE_LOG2-1:0];
            cy1_reg   <= cy_next;
            lmul1_reg <= ROWMUL_W'(pix_y[COORD_W-1:TILE_LOG2]) * ROWMUL_W'(tiles);
        end
    end

    assign lhi_next = OFF_HI_W'(lmul1_reg) + OFF_HI_W'(x1_reg[COORD_W-1:TILE_LOG2]);

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            x2_reg    <= x1_reg;
            cyl2_reg  <= cy1_reg[TILE_LOG2-1:0];
            cmul2_reg <= ROWMUL_W'(cy1_reg[COORD_W-1:TILE_LOG2]) * ROWMUL_W'(tiles);
            loff2_reg <= {lhi_next, yl1_reg, x1_reg[TILE_LOG2-1:0]};
        end
    end

    assign chi_next = OFF_HI_W'(cmul2_reg) + OFF_HI_W'(x2_reg[COORD_W-1:TILE_LOG2]);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            loff3_reg <= loff2_reg;
            coff3_reg <= {chi_next, cyl2_reg, x2_reg[TILE_LOG2-1:1], 1'b0};
        end
    end

    // Chroma pairs start on even bytes, so Cr is the Cb offset with bit zero set.
    assign luma_offset = loff3_reg;
    assign cb_offset   = coff3_reg;
    assign cr_offset   = {coff3_reg[OFF_W-1:1], 1'b1};

endmodule

// File: sv/tyc2rgb_color.sv
// ----------------------------------------------------------------------------
// tyc2rgb_color
// Three-stage Q16 YCbCr-to-RGB conversion with clamping to 0..255.
// ----------------------------------------------------------------------------
module tyc2rgb_color
    import tyc2rgb_pkg::*;
(
    input  logic              clk,
    input  stage_en_t         en,
    input  logic [BYTE_W-1:0] luma_byte,
    input  logic [BYTE_W-1:0] cb_byte,
    input  logic [BYTE_W-1:0] cr_byte,
    output logic [BYTE_W-1:0] red,
    output logic [BYTE_W-1:0] green,
    output logic [BYTE_W-1:0] blue
);

    logic signed [BYTE_W:0]   cb_s;
    logic signed [BYTE_W:0]   cr_s;

    logic [BYTE_W-1:0]        y1_reg;
    logic signed [PROD_W-1:0] p_rr1_reg;
    logic signed [PROD_W-1:0] p_gb1_reg;
    logic signed [PROD_W-1:0] p_gr1_reg;
    logic signed [PROD_W-1:0] p_bb1_reg;

    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  acc_r2_reg;
    logic signed [ACC_W-1:0]  acc_g2_reg;
    logic signed [ACC_W-1:0]  acc_b2_reg;

    logic [BYTE_W-1:0]        r3_reg;
    logic [BYTE_W-1:0]        g3_reg;
    logic [BYTE_W-1:0]        b3_reg;

    function automatic logic [BYTE_W-1:0] clamp8(input logic signed [ACC_W-1:0] acc);
        begin
            if (acc[ACC_W-1])
            begin
                return '0;
            end
            else if (acc[ACC_W-2:Q_SHIFT+BYTE_W] != '0)
            begin
                return '1;
            end
            else
            begin
                return acc[Q_SHIFT +: BYTE_W];
            end
        end
    endfunction

    assign cb_s = $signed({1'b0, cb_byte}) - $signed((BYTE_W + 1)'(128));
    assign cr_s = $signed({1'b0, cr_byte}) - $signed((BYTE_W + 1)'(128));

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            y1_reg    <= luma_byte;
            p_rr1_reg <= PROD_W'(cr_s) * $signed(PROD_W'(K_CR_R));
            p_gb1_reg <= PROD_W'(cb_s) * $signed(PROD_W'(K_CB_G));
            p_gr1_reg <= PROD_W'(cr_s) * $signed(PROD_W'(K_CR_G));
            p_bb1_reg <= PROD_W'(cb_s) * $signed(PROD_W'(K_CB_B));
        end
    end

    assign base = $signed({{(ACC_W - BYTE_W - Q_SHIFT){1'b0}}, y1_reg, {Q_SHIFT{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            acc_r2_reg <= base + ACC_W'(p_rr1_reg);
            acc_g2_reg <= base - ACC_W'(p_gb1_reg) - ACC_W'(p_gr1_reg);
            acc_b2_reg <= base + ACC_W'(p_bb1_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            r3_reg <= clamp8(acc_r2_reg);
            g3_reg <= clamp8(acc_g2_reg);
            b3_reg <= clamp8(acc_b2_reg);
        end
    end

    assign red   = r3_reg;
    assign green = g3_reg;
    assign blue  = b3_reg;

endmodule

// File: verif/tb_tiled_ycbcr_to_rgb_pixel_top.sv
// ----------------------------------------------------------------------------
// tb_tiled_ycbcr_to_rgb_pixel_top
// Self-checking bench for the tiled YCbCr-to-RGB pixel block. Pixels are
// streamed in under random source gaps and sink back-pressure. Every
// accepted pixel is converted by a bench-side model into its tiled plane
// offsets and clamped RGB value, and each result leaving the block is
// compared field by field against the oldest pending conversion.
// ----------------------------------------------------------------------------
module tb_tiled_ycbcr_to_rgb_pixel_top;

    import tyc2rgb_pkg::*;

    // The pipeline is three stages deep; drains wait a little past that.
    localparam int PIPE_DEPTH     = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 64;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_ITEMS    = 100;
    localparam int BURST_ITEMS    = 30;

    // Register indexes beyond the defined list; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int COORD_MAX = (1 << COORD_W) - 1;
    localparam int BYTE_MAX  = (1 << BYTE_W) - 1;
    localparam int CHROMA_BIAS = 128;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BYTE_W-1:0]  luma;
        logic [BYTE_W-1:0]  cb;
        logic [BYTE_W-1:0]  cr;
    } ycc_pixel_t;

    typedef struct {
        logic [OFF_W-1:0]  luma_off;
        logic [OFF_W-1:0]  cb_off;
        logic [OFF_W-1:0]  cr_off;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } rgb_pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // From bit 0: pix_x[11:0], pix_y[23:12], luma_byte[31:24], cb_byte[39:32],
    // cr_byte[47:40].
    logic [47:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // From bit 0: luma_offset[23:0], cb_offset[47:24], cr_offset[71:48],
    // red[79:72], green[87:80], blue[95:88].
    logic [95:0]           m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Bench copy of the configuration, updated on every accepted write to a defined register.
    logic [IMG_W_W-1:0] width_q;
    logic [VFAC_W-1:0]  vfac_q;

    // Conversions of accepted pixels whose results have not come out yet.
    rgb_pixel_t converted_q[$];
    int         mismatch_count;

    // Knobs shared by the test tasks and the source/sink processes.
    bit tx_gaps_on;
    bit rx_gaps_on;
    int hold_request;

    tiled_ycbcr_to_rgb_pixel_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Conversion model
    // ------------------------------------------------------------------------

    // Byte offset of (col, row) in a plane of 32x32 tiles laid out row by row.
    function automatic logic [OFF_W-1:0] tiled_addr(input int unsigned col,
                                                    input int unsigned row,
                                                    input int unsigned tiles);
        int unsigned off;
        begin
            off = (col / TILE_SIZE) * TILE_SIZE * TILE_SIZE
                + (col % TILE_SIZE)
                + (row % TILE_SIZE) * TILE_SIZE
                + (row / TILE_SIZE) * tiles * TILE_SIZE * TILE_SIZE;
            return off[OFF_W-1:0];
        end
    endfunction

    // Q16 accumulator to an 8-bit channel: clamp to 0..255, then floor.
    function automatic logic [BYTE_W-1:0] sat_channel(input int acc);
        int q;
        begin
            if (acc < 0)
            begin
                return '0;
            end
            if (acc > (BYTE_MAX << Q_SHIFT))
            begin
                return BYTE_W'(BYTE_MAX);
            end
            q = acc >>> Q_SHIFT;
            return q[BYTE_W-1:0];
        end
    endfunction

    function automatic rgb_pixel_t convert_pixel(input ycc_pixel_t p);
        rgb_pixel_t  r;
        int unsigned w;
        int unsigned f;
        int unsigned tiles;
        int unsigned chroma_row;
        int unsigned chroma_col;
        int          cbv;
        int          crv;
        int          base;
        begin
            // A zero width counts as one; widths past the maximum saturate.
            w = width_q;
            if (w == 0)
            begin
                w = 1;
            end
            if (w > MAX_WIDTH)
            begin
                w = MAX_WIDTH;
            end
            // A zero factor counts as one; a factor of three is a true divide.
            f = (vfac_q == '0) ? 1 : vfac_q;
            tiles = (w + TILE_SIZE - 1) / TILE_SIZE;

            chroma_row = p.y / f;
            chroma_col = {p.x[COORD_W-1:1], 1'b0};

            r.luma_off = tiled_addr(p.x, p.y, tiles);
            r.cb_off   = tiled_addr(chroma_col, chroma_row, tiles);
            r.cr_off   = r.cb_off + 1'b1;

            cbv  = int'(p.cb) - CHROMA_BIAS;
            crv  = int'(p.cr) - CHROMA_BIAS;
            base = int'(p.luma) << Q_SHIFT;
            r.red   = sat_channel(base + K_CR_R * crv);
            r.green = sat_channel(base - K_CB_G * cbv - K_CR_G * crv);
            r.blue  = sat_channel(base + K_CB_B * cbv);
            return r;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: configuration shadow, result check, and prediction of new
    // pixels. All three run in one block so their order within an edge is
    // fixed.
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [OFF_W-1:0] exp_val,
                               input logic [OFF_W-1:0] got_val);
        begin
            if (got_val !== exp_val)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rgb_pixel_t due;
        ycc_pixel_t pin;
        if (!rst_n)
        begin
            width_q = IMG_W_W'(1);
            vfac_q  = VFAC_W'(1);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                begin
                    width_q = cfg_data[IMG_W_W-1:0];
                end
                else if (cfg_index == REG_CHROMA_VERT)
                begin
                    vfac_q = cfg_data[VFAC_W-1:0];
                end
            end

            if (m_tvalid && m_tready)
            begin
                if (converted_q.size() == 0)
                begin
                    $error("result with no pixel pending: m_tdata %h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    due = converted_q.pop_front();
                    check_field("luma_offset", due.luma_off, m_tdata[23:0]);
                    check_field("cb_offset", due.cb_off, m_tdata[47:24]);
                    check_field("cr_offset", due.cr_off, m_tdata[71:48]);
                    check_field("red", OFF_W'(due.red), OFF_W'(m_tdata[79:72]));
                    check_field("green", OFF_W'(due.green), OFF_W'(m_tdata[87:80]));
                    check_field("blue", OFF_W'(due.blue), OFF_W'(m_tdata[95:88]));
                end
            end

            if (s_tvalid && s_tready)
            begin
                pin.x    = s_tdata[11:0];
                pin.y    = s_tdata[23:12];
                pin.luma = s_tdata[31:24];
                pin.cb   = s_tdata[39:32];
                pin.cr   = s_tdata[47:40];
                converted_q.push_back(convert_pixel(pin));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink: random ready gaps per result, plus a long hold-off on request.
    // The hold-off is counted here so the source keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            gap = rx_gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_tvalid);
        end
    end

    // Ends the run if no channel moves an item for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("tb_tiled_ycbcr_to_rgb_pixel_top NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Offers one pixel and returns at the edge that accepts it. tvalid stays
    // high afterwards so back-to-back pixels leave no bubble; it is only
    // lowered when a gap is drawn or by wait_drain.
    task automatic send_pixel(input ycc_pixel_t p);
        int gap;
        begin
            gap = tx_gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {p.cr, p.cb, p.luma, p.y, p.x};
            do
            begin
                @(posedge clk);
            end
            while (!s_tready);
        end
    endtask

    // Stops the source and waits until every pending result has come out.
    task automatic wait_drain();
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (converted_q.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (PIPE_DEPTH + 2) @(posedge clk);
        end
    endtask

    // Register write; only called with the pipeline empty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // The factor register only keeps its low bits, so the rest carry noise.
    task automatic write_vfac(input int f);
        logic [CFG_DATA_W-1:0] val;
        begin
            val = CFG_DATA_W'($urandom);
            val[VFAC_W-1:0] = VFAC_W'(f);
            write_reg(REG_CHROMA_VERT, val);
        end
    endtask

    function automatic ycc_pixel_t make_pixel(input int x, input int y, input int l,
                                              input int cb, input int cr);
        ycc_pixel_t p;
        begin
            p.x    = COORD_W'(x);
            p.y    = COORD_W'(y);
            p.luma = BYTE_W'(l);
            p.cb   = BYTE_W'(cb);
            p.cr   = BYTE_W'(cr);
            return p;
        end
    endfunction

    // Coordinates lean toward the ends and tile boundaries now and then.
    function automatic int rand_coord();
        begin
            case ($urandom_range(0, 9))
                0: return 0;
                1: return COORD_MAX;
                2: return TILE_SIZE * $urandom_range(0, COORD_MAX / TILE_SIZE);
                3: return TILE_SIZE * $urandom_range(1, (COORD_MAX + 1) / TILE_SIZE) - 1;
                default: return $urandom_range(0, COORD_MAX);
            endcase
        end
    endfunction

    function automatic int rand_sample();
        begin
            case ($urandom_range(0, 7))
                0: return 0;
                1: return BYTE_MAX;
                default: return $urandom_range(0, BYTE_MAX);
            endcase
        end
    endfunction

    function automatic ycc_pixel_t rand_pixel();
        begin
            return make_pixel(rand_coord(), rand_coord(), rand_sample(),
                              rand_sample(), rand_sample());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Out of reset the width and factor are both one: a single tile column.
    task automatic test_reset_defaults();
        begin
            send_pixel(make_pixel(0, 0, 0, CHROMA_BIAS, CHROMA_BIAS));
            send_pixel(make_pixel(COORD_MAX, COORD_MAX, BYTE_MAX, BYTE_MAX, BYTE_MAX));
            send_pixel(make_pixel(33, 65, 77, 12, 200));
            wait_drain();
        end
    endtask

    // Zero width, widths past the maximum, the maximum itself and a width
    // just over one tile, each probed at the far corner and at a tile seam.
    task automatic test_width_extremes();
        int widths[4];
        begin
            widths = '{0, (1 << IMG_W_W) - 1, MAX_WIDTH, TILE_SIZE + 1};
            foreach (widths[i])
            begin
                write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(widths[i]));
                send_pixel(make_pixel(COORD_MAX, COORD_MAX, rand_sample(),
                                      rand_sample(), rand_sample()));
                send_pixel(make_pixel(TILE_SIZE - 1, TILE_SIZE + 1, rand_sample(),
                                      rand_sample(), rand_sample()));
                wait_drain();
            end
        end
    endtask

    // Every vertical factor including the zero and divide-by-three cases.
    task automatic test_vert_factor();
        begin
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(MAX_WIDTH));
            for (int f = 0; f < (1 << VFAC_W); f++)
            begin
                write_vfac(f);
                send_pixel(make_pixel(COORD_MAX - 1, COORD_MAX, rand_sample(),
                                      rand_sample(), rand_sample()));
                send_pixel(make_pixel(1, 2 * TILE_SIZE + 5, rand_sample(),
                                      rand_sample(), rand_sample()));
                wait_drain();
            end
        end
    endtask

    // Chroma corners drive red and blue into both clamps and green into its low clamp.
    task automatic test_color_clamps();
        begin
            send_pixel(make_pixel(0, 0, 0, 0, 0));
            send_pixel(make_pixel(1, 1, BYTE_MAX, BYTE_MAX, BYTE_MAX));
            send_pixel(make_pixel(2, 2, 0, BYTE_MAX, 0));
            send_pixel(make_pixel(3, 3, BYTE_MAX, 0, BYTE_MAX));
            send_pixel(make_pixel(4, 4, CHROMA_BIAS, CHROMA_BIAS, CHROMA_BIAS));
            send_pixel(make_pixel(5, 5, 0, 0, BYTE_MAX));
            wait_drain();
        end
    endtask

    // Writes to indexes past the register list leave the conversion alone.
    task automatic test_unknown_register();
        begin
            write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
            write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
            send_pixel(rand_pixel());
            wait_drain();
        end
    endtask

    // The sink stops for a long stretch while the source streams without
    // gaps, so the pipeline fills and input ready drops; the source then
    // pauses until everything has drained.
    task automatic test_backpressure();
        begin
            tx_gaps_on = 1'b0;
            rx_gaps_on = 1'b0;
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1, MAX_WIDTH)));
            write_vfac($urandom_range(1, 2));
            hold_request = HOLD_CYCLES;
            repeat (BURST_ITEMS) send_pixel(rand_pixel());
            wait_drain();
        end
    endtask

    // Random pixels in phases; each phase picks new settings and a new mix
    // of source gaps and sink stalls, including runs with neither.
    task automatic test_random_stream();
        int w;
        begin
            for (int ph = 0; ph < PHASE_COUNT; ph++)
            begin
                case (ph)
                    0: w = MAX_WIDTH;
                    1: w = 1;
                    2: w = (1 << IMG_W_W) - 1;
                    3: w = 0;
                    4: w = TILE_SIZE;
                    default: w = $urandom_range(0, (1 << IMG_W_W) - 1);
                endcase
                write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
                write_vfac((ph < 4) ? ph : $urandom_range(0, 3));
                tx_gaps_on = (ph % 4 == 0) || (ph % 4 == 2);
                rx_gaps_on = (ph % 4 == 0) || (ph % 4 == 3);
                repeat (PHASE_ITEMS) send_pixel(rand_pixel());
                wait_drain();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_IMAGE_WIDTH;
        cfg_data       = '0;
        mismatch_count = 0;
        tx_gaps_on     = 1'b1;
        rx_gaps_on     = 1'b1;
        hold_request   = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_width_extremes();
        test_vert_factor();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        test_color_clamps();
        test_unknown_register();
        test_backpressure();
        test_random_stream();

        if (converted_q.size() != 0)
        begin
            $error("%0d results never arrived", converted_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
        begin
            $display("tb_tiled_ycbcr_to_rgb_pixel_top OK");
        end
        else
        begin
            $display("tb_tiled_ycbcr_to_rgb_pixel_top NOT OK");
        end
        $finish;
    end

endmodule
